// ===== rtl/core/esr_pkg.sv =====
// Shared types, constants and helpers for the escaped pixel stream receiver.
// No dependencies; every other file in rtl/core except esr_if refers to this package by scoped name.
package esr_pkg;

  localparam int PIXEL_COUNT = 64;
  localparam int PIX_CNT_W   = $clog2(PIXEL_COUNT + 1);

  localparam logic [7:0] ESC_BYTE = 8'hFF;

  localparam logic [7:0] OP_FILL     = 8'h10;
  localparam logic [7:0] OP_LIST     = 8'h11;
  localparam logic [7:0] OP_OPEN     = 8'h12;
  localparam logic [7:0] OP_WRITE    = 8'h13;
  localparam logic [7:0] OP_CLOSE    = 8'h14;
  localparam logic [7:0] OP_STATUS   = 8'h20;
  localparam logic [7:0] OP_VERSION  = 8'h21;
  localparam logic [7:0] OP_RESTART  = 8'h30;

  localparam logic [3:0] THRESH_RESET = 4'd8;

  // configuration register map
  localparam int          CFG_ADDR_W     = 3;
  localparam logic        CFG_IDX_THRESH = 1'b0;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // one queued entry: a result, optionally followed by a command end
  typedef struct packed {
    kind_t      kind;
    logic [5:0] pixel_number;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opcode;
    logic [7:0] payload_position;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       cmd_known;
    logic       end_follows;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic opcode_known(input logic [7:0] op);
    logic k;
    case (op) inside
      OP_FILL, OP_LIST, OP_OPEN, OP_WRITE, OP_CLOSE,
      OP_STATUS, OP_VERSION, OP_RESTART: k = 1'b1;
      default:                           k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/esr_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result words.
// Depends on esr_pkg for nothing but is compiled after it.
interface esr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface esr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] pixel_number;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] opcode;
  logic [7:0] payload_position;
  logic [7:0] payload_byte;
  logic [7:0] payload_length;
  logic       command_known;

  modport source (output valid, output kind, output pixel_number, output red, output green,
                  output blue, output opcode, output payload_position, output payload_byte,
                  output payload_length, output command_known, input ready);
  modport sink   (input valid, input kind, input pixel_number, input red, input green,
                  input blue, input opcode, input payload_position, input payload_byte,
                  input payload_length, input command_known, output ready);
endinterface

// ===== rtl/core/escaped_pixel_stream_receiver.sv =====
// Top level of the escaped pixel stream receiver: config register, front end, queue, output stage.
// Depends on esr_pkg, esr_if, esr_front, esr_queue and esr_back.
//
//  channel   dir   handshake          contents
//  in_ch     in    valid/ready        rx_byte, one received byte per word
//  out_ch    out   valid/ready        kind, pixel, colour, command fields
//  cfg_*     in    APB write/read     escape_threshold at byte addresses 0 to 3
//
// One byte is accepted per cycle while the four-entry queue has room; results leave one per cycle
// while out_ch.ready is high. A last payload byte yields two words (payload, then command end).
// Each word is registered in the queue and then in the result register that drives out_ch.
// A stalled output fills the queue, after which in_ch.ready drops; nothing is lost.
// rst_n is synchronous and clears parser state, the queue and the threshold (to 8).
module escaped_pixel_stream_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  esr_in_if.sink                         in_ch,
  esr_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [esr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic [3:0]       thresh_r;
  logic             push, pop, end_pend;
  esr_pkg::rec_t    push_rec, head;
  esr_pkg::q_stat_t q_stat;
  logic             cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[2] == esr_pkg::CFG_IDX_THRESH;
  assign cfg_prdata = cfg_hit ? {28'd0, thresh_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= esr_pkg::THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      thresh_r <= cfg_pwdata[3:0];
    end
  end

  esr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .threshold(thresh_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  esr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  esr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .end_pend(end_pend),
    .out_ch  (out_ch)
  );

  // a taken payload word with a pending end is followed by the command end
  a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && end_pend |=>
      out_ch.valid && out_ch.kind == esr_pkg::KIND_END)
    else $error("command end did not follow last payload word");

  a_known_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.command_known |-> out_ch.kind == esr_pkg::KIND_END)
    else $error("command_known set on a word other than command end");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(push && q_stat.full))
    else $error("queue overflow or inconsistent status");

endmodule

// ===== rtl/core/esr_front.sv =====
// Front end: accepts received bytes, runs the data/command parser and builds queue entries.
// Depends on esr_pkg and esr_in_if.
module esr_front (
  input  logic           clk,
  input  logic           rst_n,
  esr_in_if.sink         in_ch,
  input  logic [3:0]     threshold,
  input  esr_pkg::q_stat_t q_stat,
  output logic           push,
  output esr_pkg::rec_t  push_rec
);

  logic                        cmd_mode_r, cmd_mode_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic [7:0]                  red_r, red_nxt;
  logic [7:0]                  green_r, green_nxt;
  logic [esr_pkg::PIX_CNT_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic [3:0]                  esc_run_r, esc_run_nxt;
  logic [8:0]                  cmd_cnt_r, cmd_cnt_nxt;
  logic [7:0]                  opcode_r, opcode_nxt;
  logic [7:0]                  length_r, length_nxt;

  logic                        acc;
  logic [4:0]                  run;
  logic [8:0]                  cnt_new;
  logic [7:0]                  len_eff;
  logic [esr_pkg::PIX_CNT_W+5:0] pix_ext;
  logic [7:0]                  pos_full;

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign run         = {1'b0, esc_run_r} + 5'd1;
  assign pix_ext     = {6'd0, pix_cnt_r};
  assign pos_full    = 8'(cmd_cnt_r - 9'd2);

  always_comb begin
    cmd_mode_nxt = cmd_mode_r;
    phase_nxt    = phase_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    pix_cnt_nxt  = pix_cnt_r;
    esc_run_nxt  = esc_run_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    opcode_nxt   = opcode_r;
    length_nxt   = length_r;
    cnt_new      = cmd_cnt_r;
    len_eff      = length_r;
    push         = 1'b0;
    push_rec     = '0;
    if (acc) begin
      if (!cmd_mode_r) begin
        if (in_ch.rx_byte != esr_pkg::ESC_BYTE) begin
          esc_run_nxt = 4'd0;
          case (phase_r)
            2'd0: begin
              red_nxt   = in_ch.rx_byte;
              phase_nxt = 2'd1;
            end
            2'd1: begin
              green_nxt = in_ch.rx_byte;
              phase_nxt = 2'd2;
            end
            default: begin
              phase_nxt = 2'd0;
              // drop triples past the last pixel
              if (pix_cnt_r < esr_pkg::PIX_CNT_W'(esr_pkg::PIXEL_COUNT)) begin
                push                  = 1'b1;
                push_rec.kind         = esr_pkg::KIND_PIXEL;
                push_rec.pixel_number = pix_ext[5:0];
                push_rec.red          = red_r;
                push_rec.green        = green_r;
                push_rec.blue         = in_ch.rx_byte;
                pix_cnt_nxt           = pix_cnt_r + 1'b1;
              end
            end
          endcase
        end else begin
          phase_nxt   = 2'd0;
          pix_cnt_nxt = '0;
          esc_run_nxt = run[4] ? 4'd15 : run[3:0];
          if (run == 5'd1) begin
            push          = 1'b1;
            push_rec.kind = esr_pkg::KIND_REFRESH;
          end
          // compare before saturation
          if (run > {1'b0, threshold}) begin
            cmd_mode_nxt = 1'b1;
            cmd_cnt_nxt  = 9'd0;
          end
        end
      end else begin
        if (cmd_cnt_r == 9'd0) begin
          // skip leading escapes
          if (in_ch.rx_byte != esr_pkg::ESC_BYTE) begin
            opcode_nxt  = in_ch.rx_byte;
            cmd_cnt_nxt = 9'd1;
          end
        end else begin
          if (cmd_cnt_r == 9'd1) begin
            length_nxt = in_ch.rx_byte;
            len_eff    = in_ch.rx_byte;
            cnt_new    = 9'd2;
          end else begin
            push                      = 1'b1;
            push_rec.kind             = esr_pkg::KIND_PAYLOAD;
            push_rec.opcode           = opcode_r;
            push_rec.payload_position = pos_full;
            push_rec.payload_byte     = in_ch.rx_byte;
            push_rec.payload_length   = length_r;
            cnt_new                   = cmd_cnt_r + 9'd1;
          end
          cmd_cnt_nxt = cnt_new;
          if ({1'b0, cnt_new} >= 10'd2 + {2'b0, len_eff}) begin
            if (push) begin
              push_rec.end_follows = 1'b1;
            end else begin
              push                    = 1'b1;
              push_rec.kind           = esr_pkg::KIND_END;
              push_rec.opcode         = opcode_r;
              push_rec.payload_length = len_eff;
            end
            push_rec.cmd_known = esr_pkg::opcode_known(opcode_r);
            cmd_mode_nxt = 1'b0;
            phase_nxt    = 2'd0;
            pix_cnt_nxt  = '0;
            esc_run_nxt  = 4'd0;
            cmd_cnt_nxt  = 9'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_mode_r <= 1'b0;
      phase_r    <= 2'd0;
      red_r      <= 8'd0;
      green_r    <= 8'd0;
      pix_cnt_r  <= '0;
      esc_run_r  <= 4'd0;
      cmd_cnt_r  <= 9'd0;
      opcode_r   <= 8'd0;
      length_r   <= 8'd0;
    end else begin
      cmd_mode_r <= cmd_mode_nxt;
      phase_r    <= phase_nxt;
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
      esc_run_r  <= esc_run_nxt;
      cmd_cnt_r  <= cmd_cnt_nxt;
      opcode_r   <= opcode_nxt;
      length_r   <= length_nxt;
    end
  end

endmodule

// ===== rtl/core/esr_queue.sv =====
// Short register queue of parsed entries between the front end and the output stage.
// Depends on esr_pkg.
module esr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  esr_pkg::rec_t    push_rec,
  input  logic             pop,
  output esr_pkg::rec_t    head,
  output esr_pkg::q_stat_t q_stat
);

  esr_pkg::rec_t               mem_r [esr_pkg::Q_DEPTH];
  logic [esr_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [esr_pkg::Q_PTR_W:0]   count_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (esr_pkg::Q_PTR_W + 1)'(esr_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/esr_back.sv =====
// Output stage: pops queue entries into the result register and expands a trailing command end.
// Depends on esr_pkg and esr_out_if.
module esr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  esr_pkg::rec_t    head,
  input  esr_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             end_pend,
  esr_out_if.source        out_ch
);

  logic          out_valid_r;
  logic          end_pend_r;
  esr_pkg::rec_t out_r;
  logic          taken;

  assign taken    = out_valid_r && out_ch.ready;
  assign pop      = !q_stat.empty && (!out_valid_r || (taken && !end_pend_r));
  assign end_pend = end_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      end_pend_r  <= 1'b0;
    end else if (taken && end_pend_r) begin
      // hold the word, turn it into the command end
      end_pend_r             <= 1'b0;
      out_r.kind             <= esr_pkg::KIND_END;
      out_r.payload_position <= 8'd0;
      out_r.payload_byte     <= 8'd0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      end_pend_r  <= head.end_follows;
      out_r       <= head;
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.pixel_number     = out_r.pixel_number;
  assign out_ch.red              = out_r.red;
  assign out_ch.green            = out_r.green;
  assign out_ch.blue             = out_r.blue;
  assign out_ch.opcode           = out_r.opcode;
  assign out_ch.payload_position = out_r.payload_position;
  assign out_ch.payload_byte     = out_r.payload_byte;
  assign out_ch.payload_length   = out_r.payload_length;
  assign out_ch.command_known    = (out_r.kind == esr_pkg::KIND_END) && out_r.cmd_known;

endmodule
